// ===== sv/window_slot_table_hit_test_defines.svh =====
// Assertion macros used by the window slot table top level.
`ifndef WINDOW_SLOT_TABLE_HIT_TEST_DEFINES_SVH
`define WINDOW_SLOT_TABLE_HIT_TEST_DEFINES_SVH

`ifndef ASSERT_OFF

// The condition holds in the same cycle as the trigger.
`define WST_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("window slot table check failed");

// The condition holds in the cycle after the trigger.
`define WST_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("window slot table check failed");

`else

`define WST_ASSERT_SAME(lbl, trig, cond)
`define WST_ASSERT_NEXT(lbl, trig, cond)

`endif

`endif

// ===== sv/wst_pkg.sv =====
// Shared constants and types of the window slot table.
`timescale 1ns / 1ps
`default_nettype none

package wst_pkg;

  localparam int SLOT_COUNT = 8;

  localparam logic [11:0] MAX_SIDE = 12'd2048;
  localparam logic [11:0] BASE_X   = 12'd100;
  localparam logic [11:0] BASE_Y   = 12'd90;
  localparam logic [11:0] STEP     = 12'd24;

  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_DESTROY = 3'd1;
  localparam logic [2:0] OP_LOOKUP  = 3'd2;
  localparam logic [2:0] OP_HIT     = 3'd3;
  localparam logic [2:0] OP_FOCUS   = 3'd4;
  localparam logic [2:0] OP_RELEASE = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [31:0] id;
    logic [1:0]  owner;
    logic [11:0] width;
    logic [11:0] height;
  } slot_rec_t;

  typedef struct packed {
    logic      wr_en;
    logic      clr_en;
    slot_rec_t rec;
  } store_cmd_t;

endpackage

`default_nettype wire

// ===== sv/wst_slot_store.sv =====
// Slot record memory with its valid flags.
`timescale 1ns / 1ps
`default_nettype none

module wst_slot_store #(
  parameter int SLOT_COUNT = wst_pkg::SLOT_COUNT,
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [IDX_W-1:0]    rd_addr,
  output wst_pkg::slot_rec_t       rd_rec,
  input  wire logic [IDX_W-1:0]    wr_addr,
  input  wst_pkg::store_cmd_t      cmd,
  output logic [SLOT_COUNT-1:0]    valid
);

  wst_pkg::slot_rec_t mem [SLOT_COUNT];

  // A write always creates a slot, so it also marks the entry valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end else if (cmd.clr_en) begin
      valid[wr_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= cmd.rec;
    end
    rd_rec <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== sv/window_slot_table_hit_test.sv =====
// Top level of the window slot table with pointer hit test.
//
//   channel | handshake       | fields
//   --------+-----------------+------------------------------------------------
//   request | start / busy    | operation, req_width, req_height, owner_conn,
//           |                 | target_id, point_x, point_y
//   result  | done (one cycle)| status, result_id, result_slot, result_conn,
//           |                 | pos_x, pos_y, surf_width, surf_height
//
// An item that scans the table keeps busy high while it reads one slot record
// per cycle, waits for the memory read and closes the scan; then the chosen slot
// is read again for its fields and the result is registered. A create with a bad
// size and unused operation codes skip the scan and the second read and go
// straight to registering the result. done is high in the first cycle with busy
// low, and a new item may be started in that same cycle. Reset is synchronous
// and empties the table; the next id starts at one. Results cannot be held off
// by the receiver.
`timescale 1ns / 1ps
`default_nettype none
`include "window_slot_table_hit_test_defines.svh"

module window_slot_table_hit_test #(
  parameter int SLOT_COUNT = wst_pkg::SLOT_COUNT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  operation,
  input  wire logic [11:0] req_width,
  input  wire logic [11:0] req_height,
  input  wire logic [1:0]  owner_conn,
  input  wire logic [31:0] target_id,
  input  wire logic [15:0] point_x,
  input  wire logic [15:0] point_y,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      result_id,
  output logic [2:0]       result_slot,
  output logic [1:0]       result_conn,
  output logic [11:0]      pos_x,
  output logic [11:0]      pos_y,
  output logic [11:0]      surf_width,
  output logic [11:0]      surf_height
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FETCH = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [2:0]  cur_op;
  logic [11:0] cur_width, cur_height;
  logic [1:0]  cur_conn;
  logic [31:0] cur_tid;
  logic [15:0] cur_x, cur_y;
  logic        bad_size;
  logic [31:0] next_id;

  logic [CNT_W-1:0] scan_cnt;
  logic [11:0]      scan_px, scan_py;
  logic             eval_valid;
  logic [IDX_W-1:0] eval_idx;
  logic [11:0]      eval_px, eval_py;

  logic             hit_found, foc_found;
  logic [31:0]      hit_id, foc_id;
  logic [IDX_W-1:0] hit_slot, foc_slot;
  logic [11:0]      hit_px, hit_py, foc_px, foc_py;

  logic                 accept, bad_in, scan_end;
  logic [IDX_W-1:0]     rd_addr, wr_addr;
  wst_pkg::slot_rec_t   rd_rec;
  wst_pkg::store_cmd_t  cmd;
  logic [SLOT_COUNT-1:0] valid;

  logic              ev_v, id_match, in_rect;
  logic signed [17:0] xs, ys, x_lo, x_hi, y_lo, y_hi;
  logic [12:0]        sum_x, sum_y;

  logic             found_any;
  logic [IDX_W-1:0] sel_slot;
  logic [11:0]      sel_px, sel_py;
  logic             out_clear;

  logic [1:0]  status_next;
  logic [31:0] result_id_next;
  logic [2:0]  result_slot_next;
  logic [1:0]  result_conn_next;
  logic [11:0] pos_x_next, pos_y_next, surf_width_next, surf_height_next;

  wst_slot_store #(.SLOT_COUNT(SLOT_COUNT)) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_rec  (rd_rec),
    .wr_addr (wr_addr),
    .cmd     (cmd),
    .valid   (valid)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign bad_in = (req_width == 12'd0) || (req_height == 12'd0) ||
                  (req_width > wst_pkg::MAX_SIDE) || (req_height > wst_pkg::MAX_SIDE);
  assign scan_end = (scan_cnt == CNT_W'(SLOT_COUNT)) && !eval_valid;

  assign found_any = hit_found || foc_found;
  assign sel_slot  = hit_found ? hit_slot : foc_slot;
  assign sel_px    = hit_found ? hit_px : foc_px;
  assign sel_py    = hit_found ? hit_py : foc_py;

  // Per-slot tests on the record that arrives from the memory this cycle.
  assign ev_v     = eval_valid && valid[eval_idx];
  assign id_match = (rd_rec.id == cur_tid);
  assign sum_x    = {1'b0, eval_px} + {1'b0, rd_rec.width};
  assign sum_y    = {1'b0, eval_py} + {1'b0, rd_rec.height};
  assign xs       = $signed({{2{cur_x[15]}}, cur_x});
  assign ys       = $signed({{2{cur_y[15]}}, cur_y});
  assign x_lo     = $signed({6'b0, eval_px});
  assign y_lo     = $signed({6'b0, eval_py});
  assign x_hi     = $signed({5'b0, sum_x});
  assign y_hi     = $signed({5'b0, sum_y});
  assign in_rect  = (xs >= x_lo) && (xs < x_hi) && (ys >= y_lo) && (ys < y_hi);

  assign out_clear = (result_id == 32'd0) && (surf_width == 12'd0) && (result_slot == 3'd0);

  always_comb begin
    rd_addr = (state == S_FETCH) ? sel_slot : scan_cnt[IDX_W-1:0];
    wr_addr = (state == S_EMIT) ? hit_slot : eval_idx;
    cmd.rec.id     = next_id;
    cmd.rec.owner  = cur_conn;
    cmd.rec.width  = cur_width;
    cmd.rec.height = cur_height;
    cmd.wr_en  = (state == S_EMIT) && (cur_op == wst_pkg::OP_CREATE) && !bad_size &&
                 hit_found;
    cmd.clr_en = ((state == S_SCAN) && (cur_op == wst_pkg::OP_RELEASE) && ev_v &&
                  (rd_rec.owner == cur_conn)) ||
                 ((state == S_EMIT) && (cur_op == wst_pkg::OP_DESTROY) && hit_found);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (((operation == wst_pkg::OP_CREATE) && bad_in) ||
              (operation > wst_pkg::OP_RELEASE)) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: state_next = S_EMIT;
      S_EMIT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    status_next      = wst_pkg::ST_NOT_FOUND;
    result_id_next   = '0;
    result_slot_next = '0;
    result_conn_next = '0;
    pos_x_next       = '0;
    pos_y_next       = '0;
    surf_width_next  = '0;
    surf_height_next = '0;
    unique case (cur_op)
      wst_pkg::OP_CREATE: begin
        if (bad_size) begin
          status_next = wst_pkg::ST_BAD_SIZE;
        end else if (!hit_found) begin
          status_next = wst_pkg::ST_FULL;
        end else begin
          status_next      = wst_pkg::ST_OK;
          result_id_next   = next_id;
          result_slot_next = 3'(hit_slot);
          result_conn_next = cur_conn;
          pos_x_next       = hit_px;
          pos_y_next       = hit_py;
          surf_width_next  = cur_width;
          surf_height_next = cur_height;
        end
      end
      wst_pkg::OP_DESTROY, wst_pkg::OP_LOOKUP, wst_pkg::OP_HIT, wst_pkg::OP_FOCUS: begin
        if (found_any) begin
          status_next      = wst_pkg::ST_OK;
          result_id_next   = rd_rec.id;
          result_slot_next = 3'(sel_slot);
          result_conn_next = rd_rec.owner;
          pos_x_next       = sel_px;
          pos_y_next       = sel_py;
          surf_width_next  = rd_rec.width;
          surf_height_next = rd_rec.height;
        end
      end
      wst_pkg::OP_RELEASE: status_next = wst_pkg::ST_OK;
      default: status_next = wst_pkg::ST_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      next_id    <= 32'd1;
      scan_cnt   <= '0;
      eval_valid <= 1'b0;
      hit_found  <= 1'b0;
      foc_found  <= 1'b0;
    end else begin
      state      <= state_next;
      done       <= (state == S_EMIT);
      eval_valid <= (state == S_SCAN) && (scan_cnt < CNT_W'(SLOT_COUNT));
      if (cmd.wr_en) begin
        next_id <= next_id + 32'd1;
      end
      if (accept) begin
        scan_cnt  <= '0;
        hit_found <= 1'b0;
        foc_found <= 1'b0;
      end else if ((state == S_SCAN) && (scan_cnt < CNT_W'(SLOT_COUNT))) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end
      if (eval_valid) begin
        // Strict compares keep the lowest slot among equal ids.
        if (((cur_op == wst_pkg::OP_CREATE) && !valid[eval_idx] && !hit_found) ||
            (((cur_op == wst_pkg::OP_DESTROY) || (cur_op == wst_pkg::OP_LOOKUP)) &&
             ev_v && id_match && !hit_found) ||
            ((cur_op == wst_pkg::OP_HIT) && ev_v && in_rect &&
             (!hit_found || (rd_rec.id > hit_id)))) begin
          hit_found <= 1'b1;
        end
        if (((cur_op == wst_pkg::OP_HIT) || (cur_op == wst_pkg::OP_FOCUS)) && ev_v &&
            (!foc_found || (rd_rec.id > foc_id))) begin
          foc_found <= 1'b1;
        end
      end
    end
  end

  // Payload registers follow the same conditions as the flags above.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op     <= operation;
      cur_width  <= req_width;
      cur_height <= req_height;
      cur_conn   <= owner_conn;
      cur_tid    <= target_id;
      cur_x      <= point_x;
      cur_y      <= point_y;
      bad_size   <= bad_in;
      scan_px    <= wst_pkg::BASE_X;
      scan_py    <= wst_pkg::BASE_Y;
    end else if ((state == S_SCAN) && (scan_cnt < CNT_W'(SLOT_COUNT))) begin
      scan_px <= scan_px + wst_pkg::STEP;
      scan_py <= scan_py + wst_pkg::STEP;
    end
    eval_idx <= scan_cnt[IDX_W-1:0];
    eval_px  <= scan_px;
    eval_py  <= scan_py;
    if (eval_valid) begin
      if (((cur_op == wst_pkg::OP_CREATE) && !valid[eval_idx] && !hit_found) ||
          (((cur_op == wst_pkg::OP_DESTROY) || (cur_op == wst_pkg::OP_LOOKUP)) &&
           ev_v && id_match && !hit_found) ||
          ((cur_op == wst_pkg::OP_HIT) && ev_v && in_rect &&
           (!hit_found || (rd_rec.id > hit_id)))) begin
        hit_id   <= rd_rec.id;
        hit_slot <= eval_idx;
        hit_px   <= eval_px;
        hit_py   <= eval_py;
      end
      if (((cur_op == wst_pkg::OP_HIT) || (cur_op == wst_pkg::OP_FOCUS)) && ev_v &&
          (!foc_found || (rd_rec.id > foc_id))) begin
        foc_id   <= rd_rec.id;
        foc_slot <= eval_idx;
        foc_px   <= eval_px;
        foc_py   <= eval_py;
      end
    end
    if (state == S_EMIT) begin
      status      <= status_next;
      result_id   <= result_id_next;
      result_slot <= result_slot_next;
      result_conn <= result_conn_next;
      pos_x       <= pos_x_next;
      pos_y       <= pos_y_next;
      surf_width  <= surf_width_next;
      surf_height <= surf_height_next;
    end
  end

  `WST_ASSERT_NEXT(a_accept_busy, accept, busy)
  `WST_ASSERT_SAME(a_done_idle, done, !busy)
  `WST_ASSERT_SAME(a_fail_empty, done && (status != wst_pkg::ST_OK), out_clear)
  `WST_ASSERT_SAME(a_no_write_clear, cmd.wr_en, !cmd.clr_en)

endmodule

`default_nettype wire
